// File: rtl/core/lprd_pkg.sv
// Shared constants and types of the length-prefixed ring deframer.
package lprd_pkg;

    localparam int unsigned RING_DEPTH_DEFAULT = 2048;
    localparam logic [15:0] MAX_LEN_RESET      = 16'd1500;
    localparam int unsigned FILL_W             = 12;

    localparam logic CMD_PUSH = 1'b0;

    typedef struct packed {
        logic              byte_valid;
        logic [7:0]        payload_byte;
        logic              message_end;
        logic              push_rejected;
        logic              oversize_dropped;
        logic [FILL_W-1:0] fill_level;
    } t_result;

endpackage

// File: rtl/core/lprd_if.sv
// Channel interfaces of the length-prefixed ring deframer.
interface lprd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source(output valid, output command, output data_byte, input ready);
    modport sink(input valid, input command, input data_byte, output ready);
endinterface

interface lprd_out_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic        message_end;
    logic        push_rejected;
    logic        oversize_dropped;
    logic [11:0] fill_level;

    modport source(output valid, output byte_valid, output payload_byte,
                   output message_end, output push_rejected,
                   output oversize_dropped, output fill_level, input ready);
    modport sink(input valid, input byte_valid, input payload_byte,
                 input message_end, input push_rejected,
                 input oversize_dropped, input fill_level, output ready);
endinterface

interface lprd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/lprd_core.sv
// Ring memory and the sequencer that pushes bytes and deframes messages on pop.
module lprd_core #(
    parameter int unsigned RING_DEPTH = lprd_pkg::RING_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lprd_in_if.sink            i_in,
    input  logic [15:0]        i_max_len,
    output logic               o_res_valid,
    output lprd_pkg::t_result  o_res,
    input  logic               i_res_ready
);

    localparam int unsigned AW    = $clog2(RING_DEPTH);
    localparam int unsigned IDX_W = AW + 1;
    localparam int unsigned CMP_W = (IDX_W > 17) ? IDX_W + 1 : 18;
    localparam logic [IDX_W-1:0] DEPTH_L = IDX_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] TWO_L   = IDX_W'(2);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HDR0   = 6'b000010,
        S_HDR1   = 6'b000100,
        S_SEEK   = 6'b001000,
        S_DATA   = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_commit, n_commit;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [15:0]      r_rem, n_rem;
    logic [7:0]       r_lo, n_lo;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_mend, n_mend;
    logic             r_rej, n_rej;
    logic             r_drop, n_drop;

    logic [7:0]       r_ring [RING_DEPTH];
    logic [7:0]       r_q;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [7:0]       mem_wd;

    logic [IDX_W-1:0] held;
    logic [31:0]      held_w;
    logic [IDX_W-1:0] commit_p1;
    logic [IDX_W-1:0] commit_p2;
    logic [15:0]      plen;
    logic [CMP_W-1:0] used_x;
    logic [CMP_W-1:0] need_x;

    assign held      = r_wr - r_commit;
    assign held_w    = 32'(held);
    assign commit_p1 = r_commit + IDX_W'(1);
    assign commit_p2 = r_commit + TWO_L;
    assign plen      = {r_q, r_lo};
    assign used_x    = CMP_W'(held);
    assign need_x    = CMP_W'(plen) + CMP_W'(2);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);

    always_comb begin
        o_res.byte_valid       = r_valid;
        o_res.payload_byte     = r_byte;
        o_res.message_end      = r_mend;
        o_res.push_rejected    = r_rej;
        o_res.oversize_dropped = r_drop;
        o_res.fill_level       = held_w[lprd_pkg::FILL_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_wr     = r_wr;
        n_commit = r_commit;
        n_rd     = r_rd;
        n_rem    = r_rem;
        n_lo     = r_lo;
        n_valid  = r_valid;
        n_byte   = r_byte;
        n_mend   = r_mend;
        n_rej    = r_rej;
        n_drop   = r_drop;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_commit[AW-1:0];
        mem_wd   = i_in.data_byte;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_valid = 1'b0;
                    n_byte  = 8'd0;
                    n_mend  = 1'b0;
                    n_rej   = 1'b0;
                    n_drop  = 1'b0;
                    if (i_in.command == lprd_pkg::CMD_PUSH) begin
                        if (held >= DEPTH_L) begin
                            n_rej = 1'b1;
                        end else begin
                            mem_we   = 1'b1;
                            mem_addr = r_wr[AW-1:0];
                            n_wr     = r_wr + IDX_W'(1);
                        end
                        n_state = S_RESULT;
                    end else if (r_rem != 16'd0) begin
                        mem_re   = 1'b1;
                        mem_addr = r_rd[AW-1:0];
                        n_state  = S_DATA;
                    end else if (held < TWO_L) begin
                        n_state = S_RESULT;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_HDR0;
                    end
                end
            end
            S_SEEK: begin
                if (held < TWO_L) begin
                    n_state = S_RESULT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_HDR0;
                end
            end
            S_HDR0: begin
                n_lo     = r_q;
                mem_re   = 1'b1;
                mem_addr = commit_p1[AW-1:0];
                n_state  = S_HDR1;
            end
            S_HDR1: begin
                // A frame is only taken once its whole payload is held.
                if (used_x < need_x) begin
                    n_state = S_RESULT;
                end else if (plen == 16'd0) begin
                    n_commit = commit_p2;
                    n_state  = S_SEEK;
                end else if (plen > i_max_len) begin
                    n_commit = commit_p2 + IDX_W'(plen);
                    n_drop   = 1'b1;
                    n_state  = S_SEEK;
                end else begin
                    n_rd     = commit_p2;
                    n_rem    = plen;
                    mem_re   = 1'b1;
                    mem_addr = commit_p2[AW-1:0];
                    n_state  = S_DATA;
                end
            end
            S_DATA: begin
                n_valid = 1'b1;
                n_byte  = r_q;
                n_rd    = r_rd + IDX_W'(1);
                n_rem   = r_rem - 16'd1;
                // The message's space is released with its last byte.
                if (r_rem == 16'd1) begin
                    n_mend   = 1'b1;
                    n_commit = r_rd + IDX_W'(1);
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_addr] <= mem_wd;
        end else if (mem_re) begin
            r_q <= r_ring[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr     <= '0;
            r_commit <= '0;
            r_rd     <= '0;
            r_rem    <= 16'd0;
        end else begin
            r_state  <= n_state;
            r_wr     <= n_wr;
            r_commit <= n_commit;
            r_rd     <= n_rd;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_valid <= n_valid;
        r_byte  <= n_byte;
        r_mend  <= n_mend;
        r_rej   <= n_rej;
        r_drop  <= n_drop;
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held <= DEPTH_L)
        else $error("ring holds more bytes than its depth");

    a_reject_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_rej) |-> (!r_valid && !r_drop))
        else $error("rejected push also reports pop results");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_mend) |-> (r_rem == 16'd0 && r_commit == r_rd))
        else $error("message end without release of the message");

    a_open_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_rem != 16'd0) |-> (held_w >= 32'(r_rem)))
        else $error("open message has more bytes left than the ring holds");

    a_push_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == S_IDLE) |=> (r_wr == $past(r_wr) + IDX_W'(1)))
        else $error("write index did not follow a stored byte");

endmodule

// File: rtl/core/lprd_oreg.sv
// Output register that holds one result word until the sink takes it.
module lprd_oreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  lprd_pkg::t_result  i_res,
    output logic               o_res_ready,
    lprd_out_if.source         o_out
);

    logic              r_full;
    lprd_pkg::t_result r_res;

    assign o_res_ready = !r_full || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_full <= 1'b1;
        end else if (o_out.ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid            = r_full;
    assign o_out.byte_valid       = r_res.byte_valid;
    assign o_out.payload_byte     = r_res.payload_byte;
    assign o_out.message_end      = r_res.message_end;
    assign o_out.push_rejected    = r_res.push_rejected;
    assign o_out.oversize_dropped = r_res.oversize_dropped;
    assign o_out.fill_level       = r_res.fill_level;

endmodule

// File: rtl/core/length_prefixed_ring_deframer.sv
// A push stores its byte in the ring; a pop inside an open message reads its next payload byte,
// and a pop that opens a message reads both header bytes first, skipping empty or oversized frames.
// One word is in work at a time; the single-port ring memory is read once per header byte
// and once per payload byte. An output register adds one word of slack.
// Reset clears the indices, the open message and the length limit (1500); the ring
// contents are not cleared and need no clearing pass.
module length_prefixed_ring_deframer #(
    parameter int unsigned RING_DEPTH = lprd_pkg::RING_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lprd_in_if.sink    i_in,
    lprd_cfg_if.sink   i_cfg,
    lprd_out_if.source o_out
);

    logic [15:0]       r_max_len;
    logic              res_valid;
    logic              res_ready;
    lprd_pkg::t_result res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lprd_pkg::MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.data;
        end
    end

    lprd_core #(
        .RING_DEPTH (RING_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    lprd_oreg u_oreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out       (o_out)
    );

endmodule

// File: sim/length_prefixed_ring_deframer_tb.sv
// Self-checking testbench for the length-prefixed ring deframer with a cycle-free predictor.
module length_prefixed_ring_deframer_tb;

    localparam int unsigned DEPTH         = lprd_pkg::RING_DEPTH_DEFAULT;
    localparam logic        CMD_POP       = ~lprd_pkg::CMD_PUSH;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned PHASE_WORDS   = 150;

    typedef enum {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_TOGGLE} t_stall_mode;

    class t_frame_ring_checker;
        logic [7:0]          ring [DEPTH];
        logic [11:0]         wr_idx;
        logic [11:0]         commit_idx;
        logic [11:0]         rd_cursor;
        logic [15:0]         left_in_msg;
        logic [15:0]         max_len;
        lprd_pkg::t_result   awaited [$];
        int                  mismatches;
        int                  results_seen;

        function void reset_state();
            wr_idx       = '0;
            commit_idx   = '0;
            rd_cursor    = '0;
            left_in_msg  = '0;
            max_len      = lprd_pkg::MAX_LEN_RESET;
            awaited.delete();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function logic [11:0] bytes_held();
            return wr_idx - commit_idx;
        endfunction

        function logic [7:0] ring_at(logic [11:0] idx);
            return ring[int'(idx) % DEPTH];
        endfunction

        function void set_max_len(logic [15:0] value);
            max_len = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Works out the result of one accepted word and queues it.
        function void note_command(logic cmd, logic [7:0] din);
            lprd_pkg::t_result r;
            logic [15:0]       frame_len;
            int                used;
            bit                searching;
            r = '0;
            if (cmd == lprd_pkg::CMD_PUSH) begin
                if (bytes_held() >= DEPTH) begin
                    r.push_rejected = 1'b1;
                end else begin
                    ring[int'(wr_idx) % DEPTH] = din;
                    wr_idx = wr_idx + 12'd1;
                end
            end else begin
                // With no message open, skip sentinels and oversized frames until a
                // complete frame is found or the data runs out.
                searching = (left_in_msg == 16'd0);
                while (searching) begin
                    used = int'(bytes_held());
                    if (used < 2) begin
                        searching = 1'b0;
                    end else begin
                        frame_len = {ring_at(commit_idx + 12'd1), ring_at(commit_idx)};
                        if (used < 2 + int'(frame_len)) begin
                            searching = 1'b0;
                        end else if (frame_len == 16'd0) begin
                            commit_idx = commit_idx + 12'd2;
                        end else if (frame_len > max_len) begin
                            commit_idx = 12'(int'(commit_idx) + 2 + int'(frame_len));
                            r.oversize_dropped = 1'b1;
                        end else begin
                            rd_cursor   = commit_idx + 12'd2;
                            left_in_msg = frame_len;
                            searching   = 1'b0;
                        end
                    end
                end
                if (left_in_msg != 16'd0) begin
                    r.byte_valid   = 1'b1;
                    r.payload_byte = ring_at(rd_cursor);
                    rd_cursor      = rd_cursor + 12'd1;
                    left_in_msg    = left_in_msg - 16'd1;
                    if (left_in_msg == 16'd0) begin
                        r.message_end = 1'b1;
                        commit_idx    = rd_cursor;
                    end
                end
            end
            r.fill_level = bytes_held();
            awaited.push_back(r);
        endfunction

        task report(string what, logic [11:0] got, logic [11:0] want);
            mismatches++;
            $display("[%0t] result %0d, %s: got %0h, want %0h",
                     $time, results_seen, what, got, want);
        endtask

        task check_result(lprd_pkg::t_result got);
            lprd_pkg::t_result want;
            results_seen++;
            if (awaited.size() == 0) begin
                report("result with nothing awaited", '0, '0);
            end else begin
                want = awaited.pop_front();
                if (got.byte_valid !== want.byte_valid)
                    report("byte_valid", got.byte_valid, want.byte_valid);
                if (got.payload_byte !== want.payload_byte)
                    report("payload_byte", got.payload_byte, want.payload_byte);
                if (got.message_end !== want.message_end)
                    report("message_end", got.message_end, want.message_end);
                if (got.push_rejected !== want.push_rejected)
                    report("push_rejected", got.push_rejected, want.push_rejected);
                if (got.oversize_dropped !== want.oversize_dropped)
                    report("oversize_dropped", got.oversize_dropped, want.oversize_dropped);
                if (got.fill_level !== want.fill_level)
                    report("fill_level", got.fill_level, want.fill_level);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lprd_in_if  in_if();
    lprd_cfg_if cfg_if();
    lprd_out_if out_if();

    length_prefixed_ring_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_frame_ring_checker tracker;
    int                  burst_left;
    int                  words_sent;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offers one word, waits for it to be taken and records it with the predictor.
    task automatic send_word(logic cmd, logic [7:0] din);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.data_byte <= din;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_command(cmd, din);
        words_sent++;
    endtask

    task automatic pop_word();
        send_word(CMD_POP, 8'($urandom));
    endtask

    // A broken frame has pops slipped in between its bytes before it is complete.
    task automatic push_frame(int len, bit broken);
        send_word(lprd_pkg::CMD_PUSH, len[7:0]);
        send_word(lprd_pkg::CMD_PUSH, len[15:8]);
        for (int k = 0; k < len; k++) begin
            if (broken && $urandom_range(0, 3) == 0)
                pop_word();
            send_word(lprd_pkg::CMD_PUSH, 8'($urandom));
        end
    endtask

    task automatic quiesce();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(logic [15:0] value);
        quiesce();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tracker.set_max_len(value);
    endtask

    // Mostly short frames, with sentinels and, for a limit of at most 64, lengths close to it mixed in.
    function automatic int pick_len(logic [15:0] limit);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            len = 0;
        end else if (r < 30 && limit <= 16'd64) begin
            len = int'(limit) + int'($urandom_range(0, 4)) - 2;
            if (len < 1) len = 1;
        end else if (r < 85) begin
            len = $urandom_range(1, 12);
        end else begin
            len = $urandom_range(13, 48);
        end
        return len;
    endfunction

    task automatic run_traffic(int words);
        int first;
        int len;
        int r;
        first = words_sent;
        while (words_sent - first < words) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = pick_len(tracker.max_len);
                // A rejected push would break the framing, so keep clear of a full ring.
                if (int'(tracker.bytes_held()) + len + 12 > DEPTH)
                    repeat (8) pop_word();
                else
                    push_frame(len, $urandom_range(0, 4) == 0);
            end else if (r < 93) begin
                repeat ($urandom_range(1, 6)) pop_word();
            end else begin
                repeat ($urandom_range(8, 20)) pop_word();
            end
        end
    endtask

    initial begin
        logic [15:0] phase_limits [6];
        tracker = new();
        tracker.reset_state();
        burst_left      = 0;
        words_sent      = 0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.command   <= lprd_pkg::CMD_PUSH;
        in_if.data_byte <= 8'h00;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= 16'h0000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit: empty ring, a header that arrives a byte at a time, a one-byte
        // message, then a sentinel ahead of a two-byte message.
        pop_word();
        send_word(lprd_pkg::CMD_PUSH, 8'h01);
        pop_word();
        send_word(lprd_pkg::CMD_PUSH, 8'h00);
        pop_word();
        send_word(lprd_pkg::CMD_PUSH, 8'hFF);
        pop_word();
        push_frame(0, 1'b0);
        send_word(lprd_pkg::CMD_PUSH, 8'h02);
        send_word(lprd_pkg::CMD_PUSH, 8'h00);
        send_word(lprd_pkg::CMD_PUSH, 8'h00);
        send_word(lprd_pkg::CMD_PUSH, 8'h80);
        pop_word();
        pop_word();

        // Limit of one: the two-byte frame is discarded on the way to the next one.
        write_max_len(16'd1);
        send_word(lprd_pkg::CMD_PUSH, 8'h02);
        send_word(lprd_pkg::CMD_PUSH, 8'h00);
        send_word(lprd_pkg::CMD_PUSH, 8'h55);
        send_word(lprd_pkg::CMD_PUSH, 8'hAA);
        send_word(lprd_pkg::CMD_PUSH, 8'h01);
        send_word(lprd_pkg::CMD_PUSH, 8'h00);
        send_word(lprd_pkg::CMD_PUSH, 8'h7F);
        pop_word();
        pop_word();

        phase_limits[0] = 16'd0;
        phase_limits[1] = 16'hFFFF;
        phase_limits[2] = 16'd8;
        phase_limits[3] = 16'($urandom_range(2, 40));
        phase_limits[4] = 16'd1;
        phase_limits[5] = lprd_pkg::MAX_LEN_RESET;
        foreach (phase_limits[p]) begin
            write_max_len(phase_limits[p]);
            run_traffic(PHASE_WORDS);
        end
        while (tracker.bytes_held() != 0) pop_word();

        // A header claiming more than the ring can ever hold stays incomplete.
        send_word(lprd_pkg::CMD_PUSH, 8'hFF);
        send_word(lprd_pkg::CMD_PUSH, 8'hFF);
        repeat (4) send_word(lprd_pkg::CMD_PUSH, 8'($urandom));
        repeat (3) pop_word();

        quiesce();
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: checks every accepted word and drives ready on a stall pattern,
    // with one long hold-off so that the block backs up into its input.
    initial begin
        int                hold_left;
        int                mode_left;
        bit                hold_done;
        t_stall_mode       mode;
        lprd_pkg::t_result got;
        hold_left = 0;
        mode_left = 0;
        hold_done = 1'b0;
        mode      = STALL_NONE;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.byte_valid       = out_if.byte_valid;
                got.payload_byte     = out_if.payload_byte;
                got.message_end      = out_if.message_end;
                got.push_rejected    = out_if.push_rejected;
                got.oversize_dropped = out_if.oversize_dropped;
                got.fill_level       = out_if.fill_level;
                tracker.check_result(got);
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!hold_done && tracker.results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else begin
                case (mode)
                    STALL_NONE:   out_if.ready <= 1'b1;
                    STALL_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
                    STALL_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default:      out_if.ready <= ~out_if.ready;
                endcase
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

// File: length_prefixed_ring_deframer.f
rtl/core/lprd_pkg.sv
rtl/core/lprd_if.sv
rtl/core/lprd_core.sv
rtl/core/lprd_oreg.sv
rtl/core/length_prefixed_ring_deframer.sv
sim/length_prefixed_ring_deframer_tb.sv
